@@ hdl/mscn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mscn_pkg
// Shared types, constants and helpers of the move sequence nibble codec.
// ----------------------------------------------------------------------------
package mscn_pkg;

    localparam int MAX_MOVES_DEFAULT = 20;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic       DIR_ENCODE   = 1'b0;
    localparam logic [3:0] NO_FACE      = 4'd15;
    localparam logic       HEADER_MARK  = 1'b1;
    localparam logic [5:0] TURNS_PER_FACE = 6'd3;

    typedef struct packed {
        logic [4:0] prev_move;
        logic [5:0] pos;
        logic [3:0] pend;
        logic       first_bit;
        logic [3:0] last_face;
        logic [5:0] remaining;
        logic       header_seen;
    } state_t;

    localparam state_t STATE_RESET = '{
        prev_move:   5'd0,
        pos:         6'd0,
        pend:        4'd0,
        first_bit:   1'b0,
        last_face:   NO_FACE,
        remaining:   6'd0,
        header_seen: 1'b0
    };

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       error;
    } result_t;

    localparam result_t RESULT_NONE  = '{value: 8'd0, last: 1'b0, error: 1'b0};
    localparam result_t RESULT_ERROR = '{value: 8'd0, last: 1'b0, error: 1'b1};

    // Face of a move: v / 3 for v below 32, by reciprocal multiplication.
    function automatic logic [3:0] face_of(input logic [4:0] v);
        logic [8:0] p;
        p = 9'(v) * 9'd11;
        return p[8:5];
    endfunction

endpackage : mscn_pkg
`default_nettype wire

@@ hdl/mscn_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mscn_step
// Single-pass logic for one item: next sequence state and up to two results.
// ----------------------------------------------------------------------------
module mscn_step #(
    parameter int MAX_MOVES = mscn_pkg::MAX_MOVES_DEFAULT
) (
    input  wire logic              direction,
    input  wire mscn_pkg::state_t  state_in,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    output mscn_pkg::state_t       state_out,
    output logic [1:0]             res_count,
    output mscn_pkg::result_t      res0,
    output mscn_pkg::result_t      res1
);

    localparam logic [5:0] MaxPos = 6'(MAX_MOVES);

    mscn_pkg::state_t  st;
    mscn_pkg::result_t res [2];
    logic [1:0] n;
    logic [4:0] mv;
    logic [3:0] code;
    logic [3:0] dcode;
    logic [5:0] m;
    logic [3:0] face;
    logic       do_flush;
    logic       flush_err;
    logic [5:0] len;

    always_comb begin
        st        = state_in;
        n         = 2'd0;
        res[0]    = mscn_pkg::RESULT_NONE;
        res[1]    = mscn_pkg::RESULT_NONE;
        mv        = in_byte[4:0];
        code      = 4'd0;
        dcode     = 4'd0;
        m         = 6'd0;
        face      = 4'd0;
        do_flush  = 1'b0;
        flush_err = 1'b0;
        len       = in_byte[5:0];

        if (direction == mscn_pkg::DIR_ENCODE) begin
            if (st.pos >= MaxPos) begin
                if (!in_last) begin
                    res[0] = mscn_pkg::RESULT_ERROR;
                    n      = 2'd1;
                end else begin
                    do_flush  = 1'b1;
                    flush_err = 1'b1;
                end
            end else begin
                if (st.pos == 6'd0) begin
                    st.first_bit = mv[0];
                    code         = mv[4:1];
                end else if (st.prev_move < mv) begin
                    code = 4'(mv - 5'd3);
                end else begin
                    code = mv[3:0];
                end
                st.prev_move = mv;
                if (!st.pos[0]) begin
                    st.pend = code;
                end else begin
                    res[0] = '{value: {st.pend, code}, last: 1'b0, error: 1'b0};
                    n      = 2'd1;
                end
                st.pos   = st.pos + 6'd1;
                do_flush = in_last;
            end
            if (do_flush) begin
                if (st.pos[0]) begin
                    res[n[0]] = '{value: {st.pend, 4'd0}, last: 1'b0, error: flush_err};
                    n         = n + 2'd1;
                end
                res[n[0]] = '{value: {mscn_pkg::HEADER_MARK, st.first_bit, st.pos},
                              last: 1'b1, error: flush_err};
                n  = n + 2'd1;
                st = mscn_pkg::STATE_RESET;
            end
        end else if (!st.header_seen) begin
            if (len > MaxPos) begin
                res[0] = mscn_pkg::RESULT_ERROR;
                n      = 2'd1;
            end else begin
                st = mscn_pkg::STATE_RESET;
                if (len != 6'd0) begin
                    st.first_bit   = in_byte[6];
                    st.remaining   = len;
                    st.header_seen = 1'b1;
                end
            end
        end else begin
            for (int h = 0; h < 2; h++) begin
                if (st.remaining != 6'd0) begin
                    dcode = (h == 0) ? in_byte[7:4] : in_byte[3:0];
                    if (st.pos == 6'd0) begin
                        m = {1'b0, dcode, st.first_bit};
                    end else begin
                        m = {2'b00, dcode};
                    end
                    face = mscn_pkg::face_of(m[4:0]);
                    if (st.last_face != mscn_pkg::NO_FACE && st.last_face <= face) begin
                        m    = m + mscn_pkg::TURNS_PER_FACE;
                        face = face + 4'd1;
                    end
                    st.last_face = face;
                    st.pos       = st.pos + 6'd1;
                    st.remaining = st.remaining - 6'd1;
                    res[n[0]]    = '{value: {2'b00, m}, last: (st.remaining == 6'd0),
                                     error: 1'b0};
                    n            = n + 2'd1;
                end
            end
            if (st.remaining == 6'd0) begin
                st = mscn_pkg::STATE_RESET;
            end
        end
    end

    assign state_out = st;
    assign res_count = n;
    assign res0      = res[0];
    assign res1      = res[1];

endmodule : mscn_step
`default_nettype wire

@@ hdl/mscn_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mscn_out_fifo
// Small result queue that takes up to two results per cycle and gives one.
// ----------------------------------------------------------------------------
module mscn_out_fifo (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [1:0]                      push_count,
    input  wire mscn_pkg::result_t               push0,
    input  wire mscn_pkg::result_t               push1,
    input  wire logic                            pop,
    output logic [mscn_pkg::FIFO_CNT_W-1:0]      count,
    output mscn_pkg::result_t                    head
);

    mscn_pkg::result_t mem_reg [mscn_pkg::FIFO_DEPTH];
    logic [mscn_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mscn_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mscn_pkg::FIFO_CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + mscn_pkg::FIFO_PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + mscn_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + mscn_pkg::FIFO_CNT_W'(push_count)
                    - mscn_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            mem_reg[wr_ptr_reg + mscn_pkg::FIFO_PTR_W'(1)] <= push1;
        end
    end

    assign count = count_reg;
    assign head  = mem_reg[rd_ptr_reg];

endmodule : mscn_out_fifo
`default_nettype wire

@@ hdl/move_sequence_nibble_codec_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// move_sequence_nibble_codec_unit
// Packs puzzle move sequences into nibble records and unpacks them again.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_        in         tdata[7:0] move or record byte, tlast final move
//  m_        out        tdata[7:0] record byte or move, tlast, tuser[0] error
//  cfg_      in         wr_data direction (0 encode, 1 decode)
//
//  An accepted item waits in the input register until the queue has room for
//  two results; it is processed in a single pass and its results enter a
//  four-entry queue. Items with at most one result flow at one per cycle while
//  the output accepts; items with two results are limited by the single output
//  port. A direction write clears the sequence state. Reset is synchronous.
//  A stalled output holds its transfer while the queue takes items as room allows.
// ----------------------------------------------------------------------------
module move_sequence_nibble_codec_unit #(
    parameter int MAX_MOVES = mscn_pkg::MAX_MOVES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_value
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // [0] error
);

    logic                 direction_reg;
    mscn_pkg::state_t     state_reg;
    mscn_pkg::state_t     state_next;
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;

    logic [1:0]           res_count;
    mscn_pkg::result_t    res0;
    mscn_pkg::result_t    res1;
    mscn_pkg::result_t    head;
    logic [mscn_pkg::FIFO_CNT_W-1:0] fifo_count;
    logic                 pop;
    logic                 fire;
    logic                 room;

    assign pop  = m_tvalid && m_tready;
    assign room = (mscn_pkg::FIFO_CNT_W'(mscn_pkg::FIFO_DEPTH) - fifo_count
                  + mscn_pkg::FIFO_CNT_W'(pop)) >= mscn_pkg::FIFO_CNT_W'(2);
    assign fire = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= mscn_pkg::DIR_ENCODE;
            state_reg     <= mscn_pkg::STATE_RESET;
        end else if (cfg_wr_en) begin
            direction_reg <= cfg_wr_data;
            state_reg     <= mscn_pkg::STATE_RESET;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    mscn_step #(
        .MAX_MOVES (MAX_MOVES)
    ) u_step (
        .direction (direction_reg),
        .state_in  (state_reg),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .state_out (state_next),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    mscn_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (fire ? res_count : 2'd0),
        .push0      (res0),
        .push1      (res1),
        .pop        (pop),
        .count      (fifo_count),
        .head       (head)
    );

    assign m_tvalid = (fifo_count != '0);
    assign m_tdata  = head.value;
    assign m_tlast  = head.last;
    assign m_tuser  = head.error;

endmodule : move_sequence_nibble_codec_unit
`default_nettype wire

@@ verif/move_sequence_nibble_codec_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_sequence_nibble_codec_unit_test
// Self-checking testbench for the move sequence nibble codec. A behavioral
// model in this file predicts every record byte and decoded move from the
// accepted input transfers. Each output transfer is compared field by field
// against the oldest prediction. Both stream sides idle at random. Directed
// tests cover the extremes and the corner cases, and random tests cover
// canonical sequences and records mixed with noise. One test holds the
// output off long enough to stall the input.
// ----------------------------------------------------------------------------
module move_sequence_nibble_codec_unit_test;

    localparam int         MOVE_LIMIT    = mscn_pkg::MAX_MOVES_DEFAULT;
    localparam logic [3:0] NO_FACE       = mscn_pkg::NO_FACE;
    localparam logic       DIR_ENCODE    = mscn_pkg::DIR_ENCODE;
    localparam logic       DIR_DECODE    = ~mscn_pkg::DIR_ENCODE;
    localparam logic [7:0] HEADER_BASE   = 8'h80;
    localparam int         RESET_CYCLES  = 9;
    localparam int         DRAIN_CYCLES  = 16;
    localparam int         STALL_LIMIT   = 4000;
    localparam int         HOLD_CYCLES   = 120;
    localparam int         MAX_GAP       = 12;
    localparam int         REPORT_LIMIT  = 20;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = 8'h00;   // [7:0] in_byte
    logic       s_tlast     = 1'b0;
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;               // [7:0] out_value
    logic       m_tlast;
    logic [0:0] m_tuser;               // [0] error

    logic       codec_dir;
    logic [4:0] prev_move;
    logic [5:0] move_count;
    logic [3:0] held_nibble;
    logic       lead_bit;
    logic [3:0] prev_face;
    logic [5:0] moves_left;
    logic       in_record;

    mscn_pkg::result_t expected_results[$];

    int sent_items      = 0;
    int results_seen    = 0;
    int mismatch_count  = 0;
    int cfg_writes      = 0;
    int tx_gap_max      = 0;
    int rx_gap_max      = 0;
    int hold_off_cycles = 0;

    move_sequence_nibble_codec_unit #(
        .MAX_MOVES(MOVE_LIMIT)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_sequence_model();
        prev_move   = 5'd0;
        move_count  = 6'd0;
        held_nibble = 4'd0;
        lead_bit    = 1'b0;
        prev_face   = NO_FACE;
        moves_left  = 6'd0;
        in_record   = 1'b0;
    endfunction

    function automatic void expect_result(input logic [7:0] value, input logic last,
                                          input logic err);
        mscn_pkg::result_t r;
        r.value = value;
        r.last  = last;
        r.error = err;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void close_record(input logic err);
        if (move_count[0]) begin
            expect_result({held_nibble, 4'h0}, 1'b0, err);
        end
        expect_result(HEADER_BASE | {1'b0, lead_bit, move_count}, 1'b1, err);
        clear_sequence_model();
    endfunction

    function automatic void encode_move(input logic [4:0] mv, input logic last);
        logic [3:0] code;
        if (move_count >= MOVE_LIMIT) begin
            if (last) begin
                close_record(1'b1);
            end else begin
                expect_result(8'h00, 1'b0, 1'b1);
            end
            return;
        end
        if (move_count == 6'd0) begin
            lead_bit = mv[0];
            code     = mv[4:1];
        end else if (prev_move < mv) begin
            code = 4'(mv - 5'd3);
        end else begin
            code = mv[3:0];
        end
        prev_move = mv;
        if (!move_count[0]) begin
            held_nibble = code;
        end else begin
            expect_result({held_nibble, code}, 1'b0, 1'b0);
        end
        move_count = move_count + 6'd1;
        if (last) begin
            close_record(1'b0);
        end
    endfunction

    function automatic logic [7:0] decode_code(input logic [3:0] code);
        int mv;
        int face;
        mv = int'(code);
        if (move_count == 6'd0) begin
            mv = int'(lead_bit) | (int'(code) << 1);
        end
        face = mv / 3;
        if (prev_face != NO_FACE && int'(prev_face) <= face) begin
            mv   = mv + 3;
            face = face + 1;
        end
        prev_face  = 4'(face);
        move_count = move_count + 6'd1;
        return 8'(mv);
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        logic [3:0] code;
        logic [7:0] mv;
        int         half;
        if (!in_record) begin
            if (int'(b[5:0]) > MOVE_LIMIT) begin
                expect_result(8'h00, 1'b0, 1'b1);
                return;
            end
            clear_sequence_model();
            if (b[5:0] == 6'd0) begin
                return;
            end
            lead_bit   = b[6];
            moves_left = b[5:0];
            in_record  = 1'b1;
            return;
        end
        for (half = 0; half < 2; half++) begin
            if (moves_left != 6'd0) begin
                code       = (half == 0) ? b[7:4] : b[3:0];
                mv         = decode_code(code);
                moves_left = moves_left - 6'd1;
                expect_result(mv, moves_left == 6'd0, 1'b0);
            end
        end
        if (moves_left == 6'd0) begin
            clear_sequence_model();
        end
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch on %s at result %0d: got 0x%02h, expected 0x%02h",
                     field, results_seen, got, want);
        end
    endtask

    task automatic check_result();
        mscn_pkg::result_t want;
        results_seen++;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected transfer", m_tdata, 8'h00);
            return;
        end
        want = expected_results.pop_front();
        if (m_tdata !== want.value) begin
            report_mismatch("out_value", m_tdata, want.value);
        end
        if (m_tlast !== want.last) begin
            report_mismatch("out_last", {7'd0, m_tlast}, {7'd0, want.last});
        end
        if (m_tuser[0] !== want.error) begin
            report_mismatch("error", {7'd0, m_tuser[0]}, {7'd0, want.error});
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            codec_dir = DIR_ENCODE;
            clear_sequence_model();
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (cfg_wr_en) begin
                codec_dir = cfg_wr_data;
                clear_sequence_model();
                cfg_writes++;
            end
            if (s_tvalid && s_tready) begin
                if (codec_dir == DIR_ENCODE) begin
                    encode_move(s_tdata[4:0], s_tlast);
                end else begin
                    decode_byte(s_tdata);
                end
            end
        end
    end

    initial begin : result_sink
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = $urandom_range(rx_gap_max, 0);
            if (hold_off_cycles > 0) begin
                gap = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Run stopped: no transfer for %0d cycles.", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic send_item(input logic [7:0] data, input logic last);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sent_items++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_direction(input logic dir);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dir;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic int draw_gap_limit();
        return ($urandom_range(2, 0) == 0) ? 0 : MAX_GAP;
    endfunction

    task automatic send_move_sequence();
        int         kind;
        int         len;
        int         i;
        int         face_prev;
        logic       wide;
        logic [4:0] mv;
        kind = $urandom_range(99, 0);
        if (kind < 5) begin
            len = $urandom_range(6, 1);
            for (i = 0; i < len; i++) begin
                send_item(8'($urandom), 1'($urandom));
            end
            return;
        end
        len       = (kind < 15) ? $urandom_range(MOVE_LIMIT + 4, MOVE_LIMIT + 1)
                                : $urandom_range(MOVE_LIMIT, 1);
        wide      = ($urandom_range(9, 0) == 0);
        face_prev = -1;
        for (i = 0; i < len; i++) begin
            if (wide) begin
                send_item(8'($urandom), i == len - 1);
            end else begin
                do mv = 5'($urandom_range(17, 0)); while (int'(mv) / 3 == face_prev);
                face_prev = int'(mv) / 3;
                send_item({3'($urandom), mv} & 8'h1f, i == len - 1);
            end
        end
    endtask

    task automatic send_record();
        int         kind;
        int         len;
        int         i;
        logic [7:0] header;
        kind   = $urandom_range(99, 0);
        header = 8'($urandom);
        if (kind < 10) begin
            send_item(header, 1'($urandom));
            return;
        end
        if (kind < 20) begin
            len = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(63, MOVE_LIMIT + 1);
        end else begin
            len = $urandom_range(MOVE_LIMIT, 1);
        end
        header[5:0] = 6'(len);
        send_item(header, 1'($urandom));
        if (len >= 1 && len <= MOVE_LIMIT) begin
            for (i = 0; i < (len + 1) / 2; i++) begin
                send_item(8'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic test_encode_directed();
        tx_gap_max = MAX_GAP;
        rx_gap_max = MAX_GAP;
        write_direction(DIR_ENCODE);
        send_item(8'd0, 1'b1);
        send_item(8'd17, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'hff, 1'b1);
        send_item(8'd3, 1'b0);
        send_item(8'd9, 1'b0);
        send_item(8'd4, 1'b0);
        send_item(8'd15, 1'b1);
        send_item(8'd5, 1'b0);
        send_item(8'd8, 1'b0);
        write_direction(DIR_ENCODE);
        send_item(8'd1, 1'b1);
    endtask

    task automatic test_decode_directed();
        write_direction(DIR_DECODE);
        send_item(8'h00, 1'b1);
        send_item(8'hff, 1'b0);
        send_item(8'h15, 1'b0);
        send_item(8'hc3, 1'b0);
        send_item(8'hf0, 1'b1);
        send_item(8'h0f, 1'b0);
        send_item(8'h02, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'h5a, 1'b1);
    endtask

    task automatic test_encode_overlength();
        int i;
        write_direction(DIR_ENCODE);
        for (i = 0; i < MOVE_LIMIT + 2; i++) begin
            send_item(8'((i % 6) * 3 + (i % 3)), i == MOVE_LIMIT + 1);
        end
        for (i = 0; i < MOVE_LIMIT; i++) begin
            send_item(8'(((i + 3) % 6) * 3 + (i % 3)), i == MOVE_LIMIT - 1);
        end
        for (i = 0; i < MOVE_LIMIT + 1; i++) begin
            send_item(8'(((5 - i % 6) * 3) + 2), i == MOVE_LIMIT);
        end
    endtask

    task automatic test_encode_random(input int items);
        int stop_at;
        write_direction(DIR_ENCODE);
        stop_at = sent_items + items;
        while (sent_items < stop_at) begin
            tx_gap_max = draw_gap_limit();
            rx_gap_max = draw_gap_limit();
            send_move_sequence();
        end
    endtask

    task automatic test_decode_random(input int items);
        int stop_at;
        write_direction(DIR_DECODE);
        stop_at = sent_items + items;
        while (sent_items < stop_at) begin
            tx_gap_max = draw_gap_limit();
            rx_gap_max = draw_gap_limit();
            send_record();
        end
    endtask

    task automatic test_output_backpressure();
        int i;
        write_direction(DIR_ENCODE);
        tx_gap_max      = 0;
        rx_gap_max      = 0;
        hold_off_cycles = HOLD_CYCLES;
        for (i = 0; i < 60; i++) begin
            send_item(8'((i % 6) * 3 + (i % 3)), (i % 6) == 5);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_encode_directed();
        test_decode_directed();
        test_encode_overlength();
        test_encode_random(350);
        test_decode_random(350);
        test_output_backpressure();
        test_encode_random(120);
        test_decode_random(120);
        wait_idle();
        $display("Covered %0d input transfers and %0d output transfers over %0d direction writes,",
                 sent_items, results_seen, cfg_writes);
        $display("including over-length records, unused nibbles and a stalled output.");
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches found.", mismatch_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule
